FILE: src/tcs_pkg.sv
// Shared types and constants for the text console core.
`default_nettype none

package tcs_pkg;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;

    typedef enum logic [1:0] {
        FUNC_PRINT = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NONE  = 2'd3
    } tcs_func_t;

    typedef struct packed {
        tcs_func_t   func;
        logic [7:0]  char_code;
        logic [6:0]  cell_col;
        logic [4:0]  cell_row;
    } tcs_request_t;

    typedef struct packed {
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
        logic [10:0] cursor_linear;
        logic [7:0]  read_code;
    } tcs_result_t;

endpackage

`default_nettype wire

FILE: src/tcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: src/tcs_addr.sv
// Cell address unit: row times columns plus column.
`default_nettype none

module tcs_addr #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic [$clog2(ROWS)-1:0]         row,
    input  wire logic [$clog2(COLUMNS)-1:0]      col,
    output logic      [$clog2(COLUMNS*ROWS)-1:0] addr
);

    localparam int AW = $clog2(COLUMNS * ROWS);

    assign addr = AW'(AW'(row) * AW'(COLUMNS) + AW'(col));

endmodule

`default_nettype wire

FILE: src/text_console_with_scroll_core.sv
// Top level of the text console: cursor sequencer, cell store and address unit.
//
// Channel   Direction  Handshake           Payload
// request   in         start && !busy      tcs_request_t (func, char_code, cell_col, cell_row)
// result    out        done, one cycle     tcs_result_t (cursor, linear position, read code)
//
// Print goes from the transfer through S_DONE to the result; a print that scrolls
// first runs the copy sweep through the single RAM port pair in S_SCROLL.
// Clear writes one zero per cell in S_CLEAR; a read of a cell inside the store
// passes through S_READ, a read outside it and the unused function go to S_DONE.
// After reset the store is swept to zero with busy high.
// The result is shown for one cycle on done; the receiver cannot stall it.
`default_nettype none

module text_console_with_scroll_core
    import tcs_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire tcs_request_t request,
    output logic              done,
    output tcs_result_t       result
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int AW    = $clog2(CELLS);
    localparam int SW    = $clog2(CELLS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DONE,
        S_SCROLL,
        S_CLEAR
    } state_t;

    state_t            state_reg,  state_next;
    logic [CW-1:0]     col_reg,    col_next;
    logic [RW-1:0]     row_reg,    row_next;
    logic [SW-1:0]     sweep_reg,  sweep_next;
    logic              init_reg,   init_next;
    logic [7:0]        code_reg,   code_next;
    logic              done_reg,   done_next;
    tcs_result_t       result_reg, result_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [7:0]        ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [7:0]        ram_rdata;

    logic [RW-1:0]     unit_row;
    logic [CW-1:0]     unit_col;
    logic [AW-1:0]     unit_addr;

    logic              use_cell;
    logic              cell_ok;
    logic              copy_read;
    logic              wrap;

    tcs_ram #(
        .WIDTH (8),
        .DEPTH (CELLS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tcs_addr #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_addr (
        .row  (unit_row),
        .col  (unit_col),
        .addr (unit_addr)
    );

    // The address unit serves the cursor, except when a read request selects a cell.
    assign use_cell = (state_reg == S_IDLE) && (request.func == FUNC_READ);
    assign unit_row = use_cell ? RW'(request.cell_row) : row_reg;
    assign unit_col = use_cell ? CW'(request.cell_col) : col_reg;

    assign cell_ok  = ({1'b0, request.cell_col} < 8'(COLUMNS)) &&
                      ({2'b00, request.cell_row} < 7'(ROWS));

    assign copy_read = (state_reg == S_SCROLL) && (sweep_reg < SW'(CELLS - COLUMNS));
    assign ram_raddr = copy_read ? AW'(sweep_reg + SW'(COLUMNS)) : unit_addr;

    always_comb
    begin
        state_next  = state_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        sweep_next  = sweep_reg;
        init_next   = init_reg;
        code_next   = code_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        ram_we      = 1'b0;
        ram_waddr   = unit_addr;
        ram_wdata   = 8'd0;
        wrap        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    code_next = 8'd0;
                    case (request.func)
                        FUNC_PRINT:
                        begin
                            state_next = S_DONE;
                            if (request.char_code == NEWLINE_CODE)
                            begin
                                wrap = 1'b1;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_wdata = request.char_code;
                                if (col_reg == CW'(COLUMNS - 1))
                                begin
                                    wrap = 1'b1;
                                end
                                else
                                begin
                                    col_next = col_reg + CW'(1);
                                end
                            end
                            if (wrap)
                            begin
                                col_next = '0;
                                if (row_reg == RW'(ROWS - 1))
                                begin
                                    sweep_next = '0;
                                    state_next = S_SCROLL;
                                end
                                else
                                begin
                                    row_next = row_reg + RW'(1);
                                end
                            end
                        end
                        FUNC_CLEAR:
                        begin
                            col_next   = '0;
                            row_next   = '0;
                            sweep_next = '0;
                            init_next  = 1'b0;
                            state_next = S_CLEAR;
                        end
                        FUNC_READ:
                        begin
                            state_next = cell_ok ? S_READ : S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                code_next  = ram_rdata;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                done_next                 = 1'b1;
                result_next.cursor_col    = 7'(col_reg);
                result_next.cursor_row    = 5'(row_reg);
                result_next.cursor_linear = 11'(unit_addr);
                result_next.read_code     = code_reg;
                state_next                = S_IDLE;
            end
            S_SCROLL:
            begin
                // Each write lands in the cycle after its read; past the copied rows write zeros.
                ram_we    = (sweep_reg != '0);
                ram_waddr = AW'(sweep_reg - SW'(1));
                ram_wdata = (sweep_reg <= SW'(CELLS - COLUMNS)) ? ram_rdata : 8'd0;
                if (sweep_reg == SW'(CELLS))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    sweep_next = sweep_reg + SW'(1);
                end
            end
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = AW'(sweep_reg);
                ram_wdata = 8'd0;
                if (sweep_reg == SW'(CELLS - 1))
                begin
                    state_next = init_reg ? S_IDLE : S_DONE;
                    init_next  = 1'b0;
                end
                else
                begin
                    sweep_next = sweep_reg + SW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            col_reg   <= '0;
            row_reg   <= '0;
            sweep_reg <= '0;
            init_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            sweep_reg <= sweep_next;
            init_reg  <= init_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg   <= code_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    a_transfer_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("sequencer did not leave idle after a transfer");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, col_reg} < (CW + 1)'(COLUMNS)) && ({1'b0, row_reg} < (RW + 1)'(ROWS)))
        else $error("cursor out of range");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

endmodule

`default_nettype wire
